FILE: rtl/core/ipv4_route_prefix_lookup_defines.svh
// assertion macros used by the checker file
`ifndef IPV4_ROUTE_PREFIX_LOOKUP_DEFINES_SVH
`define IPV4_ROUTE_PREFIX_LOOKUP_DEFINES_SVH

// condition and consequence in the same cycle
`define IPRL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define IPRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/iprl_pkg.sv
package iprl_pkg;

  localparam int ADDR_W = 32;
  localparam int PORT_W = 4;
  localparam int LEN_W  = 6;

  // item action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // one table word
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } entry_t;

  // control from the sequencer to the table
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic rd_last;
  } tbl_ctl_t;

  // one scanned entry after the match stage
  typedef struct packed {
    logic              vld;
    logic              last;
    logic              hit;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } cand_t;

  // number of set bits in a mask, nibble counts then a short sum
  function automatic logic [LEN_W-1:0] count_ones(logic [ADDR_W-1:0] v);
    logic [2:0]       nib_cnt [8];
    logic [LEN_W-1:0] sum;
    for (int i = 0; i < 8; i++) begin
      nib_cnt[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
    end
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + LEN_W'(nib_cnt[i]);
    end
    return sum;
  endfunction

endpackage

FILE: rtl/core/ipv4_route_prefix_lookup.sv
// write item: written into the route memory as it is taken, busy stays low, no result
// lookup item: one table entry read per cycle from the route memory,
//   result strobed once the last entry has passed the read and match registers, busy until then
// the receiver cannot stall; each result is shown for exactly one cycle
// reset (synchronous, rst_n low) starts a clearing pass that zeroes every entry
//   of the route memory, busy stays high until it ends
module ipv4_route_prefix_lookup #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [9:0]  in_entry_index,
  input  logic [31:0] in_route_prefix,
  input  logic [31:0] in_route_mask,
  input  logic [31:0] in_route_next_hop,
  input  logic [3:0]  in_route_port,
  input  logic [31:0] in_dest_addr,
  output logic        out_strobe,
  output logic        out_found,
  output logic [31:0] out_hop_addr,
  output logic [3:0]  out_port
);
  import iprl_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [31:0]       dest_r, dest_nxt;
  logic              best_hit_r, best_hit_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;
  logic [31:0]       best_hop_r, best_hop_nxt;
  logic [3:0]        best_port_r, best_port_nxt;
  logic              strobe_r;
  logic              found_r;
  logic [31:0]       hop_r;
  logic [3:0]        port_r;

  logic              accept;
  logic              addr_last;
  logic              wr_item;
  logic              take;
  logic              done;
  tbl_ctl_t          ctl;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  cand_t             cand;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start & ~busy;
  assign addr_last = (addr_r == AW'(TABLE_DEPTH - 1));
  assign wr_item   = accept && (in_action == ACT_WRITE) &&
                     (32'(in_entry_index) < 32'(TABLE_DEPTH));

  // memory write port: clearing pass or route write
  always_comb begin
    ctl.wr_en   = (state_r == ST_CLEAR) | wr_item;
    ctl.rd_en   = (state_r == ST_SCAN);
    ctl.rd_last = addr_last;
    if (state_r == ST_CLEAR) begin
      wr_addr = addr_r;
      wr_data = '0;
    end else begin
      wr_addr = AW'(in_entry_index);
      wr_data = '{valid: 1'b1, prefix: in_route_prefix, mask: in_route_mask,
                  hop: in_route_next_hop, port: in_route_port};
    end
  end

  iprl_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (addr_r),
    .dest    (dest_r),
    .cand    (cand)
  );

  // longest match so far, lowest index kept on a tie
  assign take = cand.vld && cand.hit && (!best_hit_r || (cand.len > best_len_r));
  assign done = cand.vld && cand.last;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    dest_nxt      = dest_r;
    best_hit_nxt  = best_hit_r;
    best_len_nxt  = best_len_r;
    best_hop_nxt  = best_hop_r;
    best_port_nxt = best_port_r;
    if (take) begin
      best_hit_nxt  = 1'b1;
      best_len_nxt  = cand.len;
      best_hop_nxt  = cand.hop;
      best_port_nxt = cand.port;
    end
    case (state_r)
      ST_CLEAR: begin
        addr_nxt = addr_r + AW'(1);
        if (addr_last) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (in_action == ACT_LOOKUP)) begin
          state_nxt     = ST_SCAN;
          addr_nxt      = '0;
          dest_nxt      = in_dest_addr;
          best_hit_nxt  = 1'b0;
          best_len_nxt  = '0;
          best_hop_nxt  = '0;
          best_port_nxt = '0;
        end
      end
      ST_SCAN: begin
        addr_nxt = addr_r + AW'(1);
        if (addr_last) begin
          addr_nxt  = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      addr_r     <= '0;
      best_hit_r <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      addr_r     <= addr_nxt;
      best_hit_r <= best_hit_nxt;
      strobe_r   <= done;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dest_r      <= dest_nxt;
    best_len_r  <= best_len_nxt;
    best_hop_r  <= best_hop_nxt;
    best_port_r <= best_port_nxt;
    if (done) begin
      found_r <= best_hit_nxt;
      hop_r   <= best_hop_nxt;
      port_r  <= best_port_nxt;
    end
  end

  assign out_strobe   = strobe_r;
  assign out_found    = found_r;
  assign out_hop_addr = hop_r;
  assign out_port     = port_r;

endmodule

FILE: rtl/core/iprl_table.sv
module iprl_table #(
  parameter int TABLE_DEPTH = 1024,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  iprl_pkg::tbl_ctl_t ctl,
  input  logic [AW-1:0]     wr_addr,
  input  iprl_pkg::entry_t  wr_data,
  input  logic [AW-1:0]     rd_addr,
  input  logic [31:0]       dest,
  output iprl_pkg::cand_t   cand
);
  import iprl_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q_r;
  logic   rd_vld_r;
  logic   rd_last_r;
  cand_t  cand_r;

  // route memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // read pipeline control, then match and prefix length of the entry just read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      rd_last_r  <= 1'b0;
      cand_r.vld <= 1'b0;
      cand_r.last <= 1'b0;
    end else begin
      rd_vld_r    <= ctl.rd_en;
      rd_last_r   <= ctl.rd_en & ctl.rd_last;
      cand_r.vld  <= rd_vld_r;
      cand_r.last <= rd_last_r;
    end
    cand_r.hit  <= rd_q_r.valid & ((dest & rd_q_r.mask) == rd_q_r.prefix);
    cand_r.len  <= count_ones(rd_q_r.mask);
    cand_r.hop  <= rd_q_r.hop;
    cand_r.port <= rd_q_r.port;
  end

  assign cand = cand_r;

endmodule

FILE: rtl/core/iprl_checker.sv
`include "ipv4_route_prefix_lookup_defines.svh"

module iprl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_action,
  input logic        out_strobe,
  input logic        out_found,
  input logic [31:0] out_hop_addr,
  input logic [3:0]  out_port
);
  import iprl_pkg::*;

  logic wr_take;
  logic lk_take;
  logic miss_zero;

  // item taken this cycle, split by action
  assign wr_take   = start && !busy && (in_action == ACT_WRITE);
  assign lk_take   = start && !busy && (in_action == ACT_LOOKUP);
  assign miss_zero = (out_hop_addr == 32'd0) && (out_port == 4'd0);

  // a write item finishes at once and gives no result
  `IPRL_ASSERT_NEXT(a_write_quiet, wr_take, !busy && !out_strobe, "write item left block busy")

  // a lookup item starts a scan
  `IPRL_ASSERT_NEXT(a_lookup_busy, lk_take, busy && !out_strobe, "lookup did not start a scan")

  // results never come back to back
  `IPRL_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held two cycles")

  // a miss carries zero payload
  `IPRL_ASSERT_SAME(a_miss_zero, out_strobe && !out_found, miss_zero, "miss with nonzero payload")

endmodule

bind ipv4_route_prefix_lookup iprl_checker u_iprl_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import iprl_pkg::*;

  localparam int DEPTH          = 1024;
  localparam int WATCHDOG_LIMIT = 6000;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } route_hit_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_action;
  logic [9:0]        in_entry_index;
  logic [31:0]       in_route_prefix;
  logic [31:0]       in_route_mask;
  logic [31:0]       in_route_next_hop;
  logic [3:0]        in_route_port;
  logic [31:0]       in_dest_addr;
  logic              out_strobe;
  logic              out_found;
  logic [31:0]       out_hop_addr;
  logic [3:0]        out_port;

  // shadow copy of the route memory
  logic [ADDR_W-1:0] shadow_prefix [DEPTH];
  logic [ADDR_W-1:0] shadow_mask [DEPTH];
  logic [ADDR_W-1:0] shadow_hop [DEPTH];
  logic [PORT_W-1:0] shadow_port [DEPTH];
  bit                shadow_valid [DEPTH];

  route_hit_t        expected_routes [$];
  logic [31:0]       addr_pool [8];
  int                mismatches;
  int                idle_cycles;

  ipv4_route_prefix_lookup #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_entry_index(in_entry_index),
    .in_route_prefix(in_route_prefix),
    .in_route_mask(in_route_mask),
    .in_route_next_hop(in_route_next_hop),
    .in_route_port(in_route_port),
    .in_dest_addr(in_dest_addr),
    .out_strobe(out_strobe),
    .out_found(out_found),
    .out_hop_addr(out_hop_addr),
    .out_port(out_port)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // longest mask wins, lowest slot on a tie
  function automatic route_hit_t best_route(logic [31:0] dest);
    route_hit_t best;
    int         best_len;
    int         len;
    best     = '0;
    best_len = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (shadow_valid[i] && ((dest & shadow_mask[i]) == shadow_prefix[i])) begin
        len = $countones(shadow_mask[i]);
        if (len > best_len) begin
          best_len   = len;
          best.found = 1'b1;
          best.hop   = shadow_hop[i];
          best.port  = shadow_port[i];
        end
      end
    end
    return best;
  endfunction

  function automatic logic [31:0] prefix_mask(int len);
    if (len == 0) begin
      return 32'h0;
    end
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 0;
    end
    if (r < 80) begin
      return $urandom_range(1, 3);
    end
    if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // drive one item and hold it until taken, then update the shadow table or queue the expected result
  task automatic send_item(input logic act, input logic [9:0] idx, input logic [31:0] pfx,
                           input logic [31:0] msk, input logic [31:0] hop,
                           input logic [3:0] prt, input logic [31:0] dest);
    in_action         <= act;
    in_entry_index    <= idx;
    in_route_prefix   <= pfx;
    in_route_mask     <= msk;
    in_route_next_hop <= hop;
    in_route_port     <= prt;
    in_dest_addr      <= dest;
    start             <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (act == ACT_WRITE) begin
      shadow_prefix[idx] = pfx;
      shadow_mask[idx]   = msk;
      shadow_hop[idx]    = hop;
      shadow_port[idx]   = prt;
      shadow_valid[idx]  = 1'b1;
    end else begin
      expected_routes.push_back(best_route(dest));
    end
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // lookup fields carry junk on a write
  task automatic write_route(input logic [9:0] idx, input logic [31:0] pfx,
                             input logic [31:0] msk, input logic [31:0] hop,
                             input logic [3:0] prt);
    send_item(ACT_WRITE, idx, pfx, msk, hop, prt, $urandom);
    idle(random_gap());
  endtask

  // route fields carry junk on a lookup
  task automatic lookup(input logic [31:0] dest);
    send_item(ACT_LOOKUP, 10'($urandom), $urandom, $urandom, $urandom, 4'($urandom), dest);
    idle(random_gap());
  endtask

  task automatic test_empty_table();
    lookup(32'h0000_0000);
    lookup(32'hFFFF_FFFF);
  endtask

  // nested prefixes under a default route
  task automatic test_prefix_lengths();
    write_route(10'd1023, 32'h0, 32'h0, 32'hFFFF_FFFF, 4'hF);
    write_route(10'd0, 32'h0A00_0000, prefix_mask(8), 32'h0, 4'h0);
    write_route(10'd1, 32'h0A01_0000, prefix_mask(16), 32'h0A00_0002, 4'h2);
    write_route(10'd2, 32'h0A01_0200, prefix_mask(24), 32'h0A00_0003, 4'h3);
    write_route(10'd3, 32'h0A01_0203, prefix_mask(32), 32'h0A00_0004, 4'h4);
    lookup(32'h0A01_0203);
    lookup(32'h0A01_0209);
    lookup(32'h0A01_0909);
    lookup(32'h0A09_0909);
    lookup(32'h0B00_0000);
    lookup(32'h0000_0000);
  endtask

  // equal lengths go to the lower slot, a rewrite replaces the route
  task automatic test_tie_and_rewrite();
    write_route(10'd20, 32'hC0A8_0000, prefix_mask(16), 32'hC0A8_00AA, 4'h5);
    write_route(10'd7, 32'hC0A8_0000, prefix_mask(16), 32'hC0A8_00BB, 4'h6);
    lookup(32'hC0A8_0101);
    write_route(10'd7, 32'hC0A8_0000, prefix_mask(16), 32'hC0A8_00CC, 4'h7);
    lookup(32'hC0A8_0101);
  endtask

  // split mask, prefix bits outside the mask, default route disabled
  task automatic test_odd_masks();
    write_route(10'd30, 32'hAB00_CD00, 32'hFF00_FF00, 32'h1234_5678, 4'h8);
    lookup(32'hAB12_CD34);
    write_route(10'd31, 32'hC0A8_0001, prefix_mask(24), 32'h8765_4321, 4'h9);
    lookup(32'hC0A8_0001);
    write_route(10'd1023, 32'h0000_0001, 32'h0, 32'h0, 4'h0);
    lookup(32'h0B00_0000);
  endtask

  // random routes built around a few shared addresses so they overlap
  task automatic test_random_routes(input int count);
    logic [9:0]  idx;
    logic [31:0] base;
    logic [31:0] msk;
    logic [31:0] pfx;
    int          r;
    int          burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      base = addr_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 99) < 62) begin
        idx = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (r < 80) begin
          msk = prefix_mask($urandom_range(0, 32));
          pfx = base & msk;
        end else if (r < 90) begin
          msk = $urandom;
          pfx = base & msk;
        end else begin
          msk = prefix_mask($urandom_range(0, 32));
          pfx = $urandom;
        end
        send_item(ACT_WRITE, idx, pfx, msk, $urandom, 4'($urandom), $urandom);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          pfx = $urandom;
        end else begin
          pfx = base ^ ($urandom >> $urandom_range(4, 31));
        end
        send_item(ACT_LOOKUP, 10'($urandom), $urandom, $urandom, $urandom, 4'($urandom), pfx);
      end
      // occasional back-to-back stretch
      if (burst > 0) begin
        burst--;
      end else if ($urandom_range(0, 29) == 0) begin
        burst = $urandom_range(10, 30);
      end else begin
        idle(random_gap());
      end
    end
  endtask

  // hold off until every lookup has answered
  task automatic test_drained_pause();
    start <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk);
    idle($urandom_range(1, 20));
  endtask

  // compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    route_hit_t want;
    if (rst_n && out_strobe) begin
      if (expected_routes.size() == 0) begin
        $display("%0t unexpected result: found=%0b hop=%h port=%h",
                 $time, out_found, out_hop_addr, out_port);
        mismatches++;
      end else begin
        want = expected_routes.pop_front();
        if (out_found !== want.found) begin
          $display("%0t found mismatch: expected %0b actual %0b", $time, want.found, out_found);
          mismatches++;
        end
        if (out_hop_addr !== want.hop) begin
          $display("%0t hop_addr mismatch: expected %h actual %h", $time, want.hop,
                   out_hop_addr);
          mismatches++;
        end
        if (out_port !== want.port) begin
          $display("%0t out_port mismatch: expected %h actual %h", $time, want.port, out_port);
          mismatches++;
        end
      end
    end
  end

  // stop a hung run
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mismatches        = 0;
    idle_cycles       = 0;
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_action         <= ACT_WRITE;
    in_entry_index    <= '0;
    in_route_prefix   <= '0;
    in_route_mask     <= '0;
    in_route_next_hop <= '0;
    in_route_port     <= '0;
    in_dest_addr      <= '0;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_valid[i] = 1'b0;
    end
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) begin
      addr_pool[i] = $urandom;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_prefix_lengths();
    test_tie_and_rewrite();
    test_odd_masks();
    test_random_routes(270);
    test_drained_pause();
    test_random_routes(270);

    // let the last lookups finish
    start <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/iprl_pkg.sv
rtl/core/iprl_table.sv
rtl/core/ipv4_route_prefix_lookup.sv
rtl/core/iprl_checker.sv
test/testbench.sv
